/* design/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg: shared types and constants of the regex stream matcher
// Operation codes, token kinds, special pattern bytes and the structs
// that run between the top level and the row of matcher cells.
// ----------------------------------------------------------------------------
package rsm_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LIT  = 2'd1;
   localparam logic [1:0] KIND_STAR = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // Signals handed from one cell to the next in every cycle.
   typedef struct packed {
      logic adv;    // a literal here matched, the next position goes live
      logic skip1;  // this position is a live star
      logic skip2;  // the position before this one is a live star
   } chain_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic       clear;
      logic       wr;
      logic       caret;
      logic       fix_prev;
      logic       step;
      logic       clr_text;
      logic       at_start;
      logic       next_start;
      logic       next_anch;
      logic [1:0] wr_kind;
      logic [1:0] prev_kind;
      logic       ignore_case;
      logic [7:0] wr_byte;
      logic [7:0] text_byte;
   } cell_ctrl_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
      if (ic && c >= CH_UP_A && c <= CH_UP_Z) begin
         return c + CASE_GAP;
      end
      return c;
   endfunction

endpackage

/* design/regex_stream_matcher.sv */
// ----------------------------------------------------------------------------
// regex_stream_matcher: streaming pattern matcher
// Bit-parallel NFA over a row of pattern cells, one cell per position.
// ----------------------------------------------------------------------------
// Usage: every word on the req_ channel carries an op and a byte. Clear
// wipes the pattern and the text, append adds a pattern byte, a text byte
// advances every live position of the NFA at once, and end of text
// returns one rsp_ word with matched and pattern_overflow.
// Throughput is one word per cycle for every op while req_stall is low;
// the NFA update is a single pass through the cell row, where the star
// skips ripple from cell to cell. An end of text word gives its answer
// on rsp_ in the cycle after it is accepted, from an output register.
// The csr_ channel writes ignore_case and is always ready; write it only
// while the block is idle.
// After reset the pattern is empty, ignore_case is 0 and no answer waits.
// While an answer waits and rsp_stall is high, req_stall is high too; the
// input is taken again in the cycle the answer is taken.
// ----------------------------------------------------------------------------
module regex_stream_matcher #(
   parameter int unsigned PATTERN_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);
   import rsm_pkg::*;

   localparam int unsigned IW = $clog2(PATTERN_LEN + 1);

   logic          accept;
   logic [IW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in, ended_ff, ended_in;
   logic          alt_ff, alt_in, lasttok_ff, lasttok_in;
   logic          match_ff, match_in, at_start_ff, at_start_in;
   logic          stopped_ff, stopped_in, ic_ff;
   logic          rsp_valid_ff, rsp_valid_in, rsp_matched_ff, rsp_ovf_ff;
   logic          any_alt, any_end;
   cell_ctrl_type ctrl;
   chain_type     chain [0:PATTERN_LEN+1];
   logic [PATTERN_LEN:0] alt_hits, end_hits;

   assign req_stall            = rsp_valid_ff & rsp_stall;
   assign accept               = req_valid & ~req_stall;
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_ovf_ff;

   assign chain[0] = '0;
   for (genvar g = 0; g <= PATTERN_LEN; g++) begin : g_cell
      rsm_cell #(.INDEX(g), .IW(IW)) u_cell (
         .clock(clock), .reset(reset), .count(count_ff), .wr_idx(count_ff),
         .ctrl(ctrl), .chain_in(chain[g]), .chain_out(chain[g+1]),
         .alt_end_hit(alt_hits[g]), .end_hit(end_hits[g])
      );
   end

   assign any_alt = |alt_hits;
   assign any_end = |end_hits;

   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      ended_in    = ended_ff;
      alt_in      = alt_ff;
      lasttok_in  = lasttok_ff;
      match_in    = match_ff;
      at_start_in = at_start_ff;
      stopped_in  = stopped_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      ctrl = '0;
      ctrl.at_start    = at_start_ff;
      ctrl.ignore_case = ic_ff;
      ctrl.wr_byte     = req_byte_value;
      ctrl.text_byte   = fold(req_byte_value, ic_ff);
      ctrl.wr_kind     = KIND_LIT;
      ctrl.prev_kind   = KIND_LIT;
      if (accept) begin
         case (req_op)
            OP_CLEAR: begin
               ctrl.clear    = 1'b1;
               ctrl.clr_text = 1'b1;
               count_in   = '0;
               ovf_in     = 1'b0;
               ended_in   = 1'b0;
               alt_in     = 1'b1;
               lasttok_in = 1'b0;
            end
            OP_APPEND: begin
               ctrl.clr_text = 1'b1;
               if (!ended_ff) begin
                  if (req_byte_value == '0) begin
                     ended_in = 1'b1;
                  end else if (count_ff == IW'(PATTERN_LEN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     ctrl.wr  = 1'b1;
                     count_in = count_ff + 1'b1;
                     ctrl.fix_prev  = lasttok_ff && req_byte_value != CH_BAR;
                     ctrl.prev_kind = (req_byte_value == CH_STAR) ? KIND_STAR : KIND_LIT;
                     if (alt_ff && req_byte_value == CH_CARET) begin
                        // Anchor: the alternative starts at the following byte.
                        ctrl.caret      = 1'b1;
                        ctrl.wr_kind    = KIND_NONE;
                        ctrl.next_start = 1'b1;
                        ctrl.next_anch  = 1'b1;
                        alt_in     = 1'b0;
                        lasttok_in = 1'b0;
                     end else if (lasttok_ff && req_byte_value == CH_STAR) begin
                        ctrl.wr_kind = KIND_NONE;
                        alt_in     = 1'b0;
                        lasttok_in = 1'b0;
                     end else if (req_byte_value == CH_BAR) begin
                        ctrl.wr_kind    = KIND_NONE;
                        ctrl.next_start = 1'b1;
                        alt_in     = 1'b1;
                        lasttok_in = 1'b0;
                     end else begin
                        ctrl.wr_kind = (req_byte_value == CH_DOLL) ? KIND_END : KIND_LIT;
                        alt_in     = 1'b0;
                        lasttok_in = 1'b1;
                     end
                  end
               end
            end
            OP_TEXT: begin
               if (!stopped_ff) begin
                  if (req_byte_value == '0) begin
                     stopped_in = 1'b1;
                  end else begin
                     ctrl.step   = 1'b1;
                     match_in    = match_ff | any_alt;
                     at_start_in = 1'b0;
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
               ctrl.clr_text = 1'b1;
            end
         endcase
         if (ctrl.clr_text) begin
            match_in    = 1'b0;
            at_start_in = 1'b1;
            stopped_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         alt_ff       <= 1'b1;
         lasttok_ff   <= 1'b0;
         match_ff     <= 1'b0;
         at_start_ff  <= 1'b1;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ic_ff        <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ended_ff     <= ended_in;
         alt_ff       <= alt_in;
         lasttok_ff   <= lasttok_in;
         match_ff     <= match_in;
         at_start_ff  <= at_start_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ic_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_END) begin
         rsp_matched_ff <= match_ff | any_alt | any_end;
         rsp_ovf_ff     <= ovf_ff;
      end
   end

endmodule

/* design/rsm_cell.sv */
// ----------------------------------------------------------------------------
// rsm_cell: one pattern position of the matcher
// Holds a pattern byte, its token flags and its live bit, and hands
// advance and star-skip signals to the next cell.
// ----------------------------------------------------------------------------
module rsm_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned IW    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [IW-1:0]         count,
   input  logic [IW-1:0]         wr_idx,
   input  rsm_pkg::cell_ctrl_type ctrl,
   input  rsm_pkg::chain_type     chain_in,
   output rsm_pkg::chain_type     chain_out,
   output logic                  alt_end_hit,
   output logic                  end_hit
);
   import rsm_pkg::*;

   logic [7:0] byte_ff;
   logic [1:0] kind_ff;
   logic       start_ff, start_in;
   logic       anch_ff, anch_in;
   logic       active_ff, active_in;
   logic       valid, in_range, cur, hit, is_star, is_lit, nxt;
   logic       is_self, is_after, is_before;

   assign is_self   = 32'(wr_idx) == INDEX;
   assign is_after  = 32'(wr_idx) + 32'd1 == INDEX;
   assign is_before = 32'(wr_idx) == INDEX + 1;

   // Cells past the position after the last stored byte hold stale flags.
   assign valid    = 32'(count) > INDEX;
   assign in_range = 32'(count) >= INDEX;
   assign is_star  = valid && kind_ff == KIND_STAR;
   assign is_lit   = valid && kind_ff == KIND_LIT;
   assign cur      = active_ff | (start_ff & (~anch_ff | ctrl.at_start)) | chain_in.skip2;
   assign hit      = byte_ff == CH_DOT || fold(byte_ff, ctrl.ignore_case) == ctrl.text_byte;
   assign nxt      = chain_in.adv | (cur & is_star & hit);

   assign chain_out.adv   = cur & is_lit & hit;
   assign chain_out.skip1 = cur & is_star;
   assign chain_out.skip2 = chain_in.skip1;

   assign alt_end_hit = cur & in_range & (~valid | byte_ff == CH_BAR);
   assign end_hit     = cur & valid & kind_ff == KIND_END;

   always_comb begin
      active_in = active_ff;
      if (ctrl.clr_text) begin
         active_in = 1'b0;
      end else if (ctrl.step) begin
         active_in = nxt;
      end
      start_in = start_ff;
      anch_in  = anch_ff;
      if (ctrl.clear && INDEX == 0) begin
         start_in = 1'b1;
         anch_in  = 1'b0;
      end else if (ctrl.wr && is_after) begin
         start_in = ctrl.next_start;
         anch_in  = ctrl.next_anch;
      end else if (ctrl.wr && is_self && ctrl.caret) begin
         start_in = 1'b0;
         anch_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         start_ff  <= INDEX == 0;
         anch_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         start_ff  <= start_in;
         anch_ff   <= anch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr && is_self) begin
         byte_ff <= ctrl.wr_byte;
         kind_ff <= ctrl.wr_kind;
      end else if (ctrl.wr && ctrl.fix_prev && is_before) begin
         kind_ff <= ctrl.prev_kind;
      end
   end

endmodule

/* design/rsm_checker.sv */
// ----------------------------------------------------------------------------
// rsm_checker: port-level checks of the regex stream matcher
// Watches the top-level ports and flags handshake and answer slips.
// ----------------------------------------------------------------------------
module rsm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_op,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_matched
);
   import rsm_pkg::*;

   // An answer appears only for an end of text word taken in the cycle before.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_op == OP_END))
      else $error("answer without an end of text word");

   // The input is held back only while an answer waits.
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid)
      else $error("input stalled with no answer waiting");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("answer present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched))
      else $error("stalled answer changed");

endmodule

bind regex_stream_matcher rsm_checker u_rsm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_op(req_op), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_matched(rsp_matched)
);
